// File: hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, action and status codes, and index helpers for the
// double-ended queue unit.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W   = $clog2(DEPTH + 1);
   localparam int ACTION_W  = 3;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 2;
   localparam int COUNT_OUT_W = 5;

   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [DATA_WIDTH-1:0]  data_type;
   typedef logic [ACTION_W-1:0]    action_type;
   typedef logic [VALUE_W-1:0]     value_type;
   typedef logic [STATUS_W-1:0]    status_type;
   typedef logic [COUNT_OUT_W-1:0] count_out_type;

   localparam action_type ACT_PUSH_FRONT = 3'd0;
   localparam action_type ACT_PUSH_BACK  = 3'd1;
   localparam action_type ACT_POP_FRONT  = 3'd2;
   localparam action_type ACT_POP_BACK   = 3'd3;
   localparam action_type ACT_PEEK_FRONT = 3'd4;
   localparam action_type ACT_PEEK_BACK  = 3'd5;
   localparam action_type ACT_CLEAR      = 3'd6;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;   // capture the incoming transaction
      logic exec;   // carry out the captured action
   } cmd_type;

   function automatic idx_type idx_next(idx_type i);
      return (i == idx_type'(DEPTH - 1)) ? '0 : idx_type'(i + 1'b1);
   endfunction

   function automatic idx_type idx_prev(idx_type i);
      return (i == '0) ? idx_type'(DEPTH - 1) : idx_type'(i - 1'b1);
   endfunction

endpackage

// File: hdl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Handshake controller: accept a transaction, run it through the datapath,
// then hold the result until it is taken.
// ----------------------------------------------------------------------------
module dq_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output dq_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign cmd.load  = req_valid && (state_ff == S_IDLE);
   assign cmd.exec  = (state_ff == S_EXEC);

endmodule

// File: hdl/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Ring buffer storage with front and back indices and the entry count.
// Decodes the captured action and produces the result fields.
// ----------------------------------------------------------------------------
module dq_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  dq_pkg::cmd_type          cmd,
   input  dq_pkg::action_type       req_action,
   input  dq_pkg::value_type        req_push_value,
   output dq_pkg::value_type        rsp_read_value,
   output dq_pkg::status_type       rsp_status,
   output dq_pkg::count_out_type    rsp_entry_count
);

   dq_pkg::data_type   slots [dq_pkg::DEPTH];

   dq_pkg::action_type action_ff;
   dq_pkg::data_type   value_ff;
   dq_pkg::idx_type    front_ff, front_in;
   dq_pkg::idx_type    back_ff, back_in;
   dq_pkg::count_type  count_ff, count_in;
   dq_pkg::status_type status_ff, status_in;
   dq_pkg::data_type   rd_ff;
   logic               hit_ff, hit_in;
   logic               wr_en;
   dq_pkg::idx_type    addr;
   logic               full, empty;

   assign full  = (count_ff == dq_pkg::count_type'(dq_pkg::DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      status_in = dq_pkg::STATUS_OK;
      hit_in    = 1'b0;
      wr_en     = 1'b0;
      addr      = front_ff;
      unique case (action_ff) inside
         dq_pkg::ACT_PUSH_FRONT: begin
            addr = dq_pkg::idx_prev(front_ff);
            if (full) begin
               status_in = dq_pkg::STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               front_in = addr;
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::ACT_PUSH_BACK: begin
            addr = back_ff;
            if (full) begin
               status_in = dq_pkg::STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               back_in  = dq_pkg::idx_next(back_ff);
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_PEEK_FRONT: begin
            addr = front_ff;
            if (empty) begin
               status_in = dq_pkg::STATUS_EMPTY;
            end else begin
               hit_in = 1'b1;
               if (action_ff == dq_pkg::ACT_POP_FRONT) begin
                  front_in = dq_pkg::idx_next(front_ff);
                  count_in = count_ff - 1'b1;
               end
            end
         end
         dq_pkg::ACT_POP_BACK, dq_pkg::ACT_PEEK_BACK: begin
            addr = dq_pkg::idx_prev(back_ff);
            if (empty) begin
               status_in = dq_pkg::STATUS_EMPTY;
            end else begin
               hit_in = 1'b1;
               if (action_ff == dq_pkg::ACT_POP_BACK) begin
                  back_in  = addr;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         dq_pkg::ACT_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            count_in = '0;
         end
         default: begin
            // unused code: no change
         end
      endcase
   end

   // Capture the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         value_ff  <= dq_pkg::data_type'(req_push_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
         hit_ff   <= 1'b0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
         hit_ff   <= hit_in;
      end
   end

   // Slot storage: one port, write or registered read
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         if (wr_en) begin
            slots[addr] <= value_ff;
         end
         rd_ff <= slots[addr];
      end
   end

   assign rsp_read_value  = hit_ff ? dq_pkg::value_type'(rd_ff) : '0;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = dq_pkg::count_out_type'(count_ff);

endmodule

// File: hdl/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue on a ring buffer: push, pop and peek at either
// end, and clear. Each transaction returns one result.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+-------------------------------------
//   req     | req_valid / req_ready | req_action, req_push_value
//   rsp     | rsp_valid / rsp_ready | rsp_read_value, rsp_status,
//           |                       | rsp_entry_count
//
// A transaction runs through capture, one slot access with the index and
// count update, then the result register. The single-port slot array
// sets the execute step; the next request is taken once the result leaves.
// Reset (synchronous) empties the queue; slot contents are not cleared.
// A stall on rsp holds the result and keeps req_ready low.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  dq_pkg::action_type       req_action,
   input  dq_pkg::value_type        req_push_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dq_pkg::value_type        rsp_read_value,
   output dq_pkg::status_type       rsp_status,
   output dq_pkg::count_out_type    rsp_entry_count
);

   dq_pkg::cmd_type cmd;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   dq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_action      (req_action),
      .req_push_value  (req_push_value),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

// File: tb/double_ended_queue_unit_checker.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit_checker
// Watches the req and rsp channels of the double-ended queue unit, keeps a
// ring-buffer model of the queue, predicts the result of every accepted
// transaction and compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  dq_pkg::action_type    req_action,
   input  dq_pkg::value_type     req_push_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  dq_pkg::value_type     rsp_read_value,
   input  dq_pkg::status_type    rsp_status,
   input  dq_pkg::count_out_type rsp_entry_count,
   output int                    error_count,
   output int                    pending_count,
   output int                    full_hits,
   output int                    empty_hits
);

   timeunit 1ns;
   timeprecision 1ps;

   import dq_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      value_type     read_value;
      status_type    status;
      count_out_type entry_count;
   } outcome_type;

   data_type  ring [DEPTH];
   idx_type   head_idx;
   idx_type   tail_idx;
   count_type stored;

   outcome_type expected_outcomes [$];
   int          mismatches = 0;
   int          pending    = 0;
   int          full_seen  = 0;
   int          empty_seen = 0;

   assign error_count   = mismatches;
   assign pending_count = pending;
   assign full_hits     = full_seen;
   assign empty_hits    = empty_seen;

   function automatic idx_type ring_fwd(idx_type i);
      return idx_type'((int'(i) + 1) % DEPTH);
   endfunction

   function automatic idx_type ring_back(idx_type i);
      return idx_type'((int'(i) + DEPTH - 1) % DEPTH);
   endfunction

   // Apply one action to the model and return the result it should produce.
   function automatic outcome_type predict_outcome(action_type act, value_type value);
      outcome_type res;
      res.read_value = '0;
      res.status     = STATUS_OK;
      case (act)
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (stored == count_type'(DEPTH)) begin
               res.status = STATUS_FULL;
               full_seen++;
            end else if (act == ACT_PUSH_FRONT) begin
               head_idx = ring_back(head_idx);
               ring[head_idx] = data_type'(value);
               stored = stored + 1'b1;
            end else begin
               ring[tail_idx] = data_type'(value);
               tail_idx = ring_fwd(tail_idx);
               stored = stored + 1'b1;
            end
         end
         ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
            if (stored == '0) begin
               res.status = STATUS_EMPTY;
               empty_seen++;
            end else if (act == ACT_POP_FRONT) begin
               res.read_value = value_type'(ring[head_idx]);
               head_idx = ring_fwd(head_idx);
               stored = stored - 1'b1;
            end else if (act == ACT_POP_BACK) begin
               tail_idx = ring_back(tail_idx);
               res.read_value = value_type'(ring[tail_idx]);
               stored = stored - 1'b1;
            end else if (act == ACT_PEEK_FRONT) begin
               res.read_value = value_type'(ring[head_idx]);
            end else begin
               res.read_value = value_type'(ring[ring_back(tail_idx)]);
            end
         end
         ACT_CLEAR: begin
            head_idx = '0;
            tail_idx = '0;
            stored   = '0;
         end
         default: ;   // unused code: no change
      endcase
      res.entry_count = count_out_type'(stored);
      return res;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("checker: %0t %s mismatch, expected 0x%0h, got 0x%0h",
                     $realtime, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         head_idx = '0;
         tail_idx = '0;
         stored   = '0;
         expected_outcomes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("checker: %0t unexpected result value 0x%0h status %0d count %0d",
                           $realtime, rsp_read_value, rsp_status, rsp_entry_count);
            end else begin
               want = expected_outcomes.pop_front();
               check_field("read_value", want.read_value, rsp_read_value);
               check_field("status", want.status, rsp_status);
               check_field("entry_count", want.entry_count, rsp_entry_count);
            end
         end
         if (req_valid && req_ready)
            expected_outcomes.push_back(predict_outcome(req_action, req_push_value));
      end
      pending = expected_outcomes.size();
   end

endmodule

// File: tb/double_ended_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit_tb
// Drives the double-ended queue unit with a directed run over the empty and
// full corners followed by random fill, drain and mixed bursts, with random
// idling on both channels and one long receiver stall. A checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import dq_pkg::*;

   localparam action_type ACT_UNUSED   = 3'd7;
   localparam int         RANDOM_ITEMS = 700;
   localparam int         LIMIT_CYCLES = 200000;
   localparam int         IDLE_PCT     = 24;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   action_type    req_action;
   value_type     req_push_value;
   logic          rsp_valid;
   logic          rsp_ready;
   value_type     rsp_read_value;
   status_type    rsp_status;
   count_out_type rsp_entry_count;

   int error_count;
   int pending_count;
   int full_hits;
   int empty_hits;

   int cycle_count = 0;
   int sent_count  = 0;
   bit tx_idle_on  = 1'b1;

   always #5ns clock = ~clock;

   double_ended_queue_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   double_ended_queue_unit_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .full_hits       (full_hits),
      .empty_hits      (empty_hits)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("double_ended_queue_unit_tb: errors");
         $finish;
      end
   end

   // Offer one transaction, idling first at random, and hold it until taken.
   task automatic send_item(input action_type act, input value_type value);
      while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_push_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   function automatic value_type pick_value();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return value_type'(1) << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   // Receiver: random idling, one long hold-off while the sender keeps
   // offering, and a window with no idling at all.
   initial begin
      int rx_cycle;
      rx_cycle  = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) rx_cycle++;
         if (reset)
            rsp_ready <= 1'b0;
         else if (rx_cycle >= 1200 && rx_cycle < 1500)
            rsp_ready <= 1'b0;
         else if (rx_cycle >= 2200 && rx_cycle < 2600)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      int mode;
      int pick;
      int directed_count;
      action_type act;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_action     = ACT_CLEAR;
      req_push_value = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue: every read action rejects, then unused code, pushes and peeks
      send_item(ACT_POP_FRONT, '1);
      send_item(ACT_POP_BACK, '0);
      send_item(ACT_PEEK_FRONT, '0);
      send_item(ACT_PEEK_BACK, '1);
      send_item(ACT_UNUSED, '1);
      send_item(ACT_PUSH_FRONT, '1);
      send_item(ACT_PUSH_BACK, '0);
      send_item(ACT_PEEK_FRONT, '0);
      send_item(ACT_PEEK_BACK, '0);
      // fill to the bound, wrapping the front index below zero; full pushes, pops, clear
      for (int i = 0; i < DEPTH - 2; i++)
         send_item((i % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, value_type'(32'h8000_0001) << i);
      send_item(ACT_PUSH_FRONT, 32'h5a5a_a5a5);
      send_item(ACT_PUSH_BACK, 32'ha5a5_5a5a);
      send_item(ACT_POP_BACK, '0);
      send_item(ACT_POP_FRONT, '0);
      send_item(ACT_CLEAR, '1);
      send_item(ACT_PEEK_BACK, '0);
      directed_count = sent_count;

      mode = MODE_MIXED;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) mode = $urandom_range(MODE_MIXED);
         tx_idle_on = !(n >= 400 && n < 500);
         pick = $urandom_range(99);
         if (pick == 0)
            act = ACT_CLEAR;
         else if (pick == 1)
            act = ACT_UNUSED;
         else if (pick < ((mode == MODE_FILL) ? 72 : (mode == MODE_DRAIN) ? 27 : 51))
            act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
         else
            act = action_type'($urandom_range(ACT_PEEK_BACK, ACT_POP_FRONT));
         send_item(act, pick_value());
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("summary: %0d transactions (%0d directed), %0d full and %0d empty rejections",
               sent_count, directed_count, full_hits, empty_hits);
      if (error_count == 0 && pending_count == 0)
         $display("double_ended_queue_unit_tb: clean");
      else
         $display("double_ended_queue_unit_tb: errors");
      $finish;
   end

endmodule
